// ===== rtl/iaet_pkg.sv =====
// shared types, codes and defaults of the input action edge tracker
`default_nettype none
package iaet_pkg;

  localparam int BINDINGS_DEF    = 32;
  localparam int ACTIONS_DEF     = 16;
  localparam int EVENT_LIMIT_DEF = 1023;

  localparam int TGT_W   = 6;
  localparam int COUNT_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EVENT = 2'd1,
    MODE_RESET = 2'd2,
    MODE_END   = 2'd3
  } mode_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNBOUND   = 3'd1;
  localparam logic [2:0] ST_BAD_DEV   = 3'd2;
  localparam logic [2:0] ST_BUDGET    = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;
  localparam logic [2:0] ST_LOAD_DEV  = 3'd5;

  localparam logic [0:0] REG_EVENT_BUDGET   = 1'd0;
  localparam logic [0:0] REG_ACTIONS_IN_USE = 1'd1;

  // devices at or above this code are unknown
  localparam logic [2:0] DEV_FIRST_UNKNOWN = 3'd3;

  typedef struct packed {
    logic             valid;
    logic             down;
    logic [2:0]       device;
    logic [15:0]      code;
    logic [TGT_W-1:0] target;
  } bind_rec_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [COUNT_W-1:0] count;
    logic               press;
    logic               release_l;
  } act_rec_t;

  typedef struct packed {
    logic shift;
    logic clear_down;
  } bind_ctl_t;

  typedef struct packed {
    logic shift;
    logic release_all;
  } act_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/iaet_bind_cell.sv =====
// one binding cell of the rotating binding ring
`default_nettype none
module iaet_bind_cell import iaet_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bind_ctl_t ctl,
  input  wire bind_rec_t rec_in,
  output bind_rec_t      rec
);

  logic             valid;
  logic             down;
  logic [2:0]       device;
  logic [15:0]      code;
  logic [TGT_W-1:0] target;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      down  <= 1'b0;
    end else if (ctl.shift) begin
      valid <= rec_in.valid;
      down  <= rec_in.down;
    end else if (ctl.clear_down) begin
      down <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      device <= rec_in.device;
      code   <= rec_in.code;
      target <= rec_in.target;
    end
  end

  assign rec = '{valid: valid, down: down, device: device, code: code, target: target};

endmodule
`default_nettype wire

// ===== rtl/iaet_act_cell.sv =====
// one action cell of the rotating action ring
`default_nettype none
module iaet_act_cell import iaet_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire act_ctl_t ctl,
  input  wire act_rec_t rec_in,
  output act_rec_t      rec
);

  logic [31:0]        id;
  logic [COUNT_W-1:0] count;
  logic               press;
  logic               release_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      press     <= 1'b0;
      release_l <= 1'b0;
    end else if (ctl.shift) begin
      count     <= rec_in.count;
      press     <= rec_in.press;
      release_l <= rec_in.release_l;
    end else if (ctl.release_all && count != '0) begin
      count     <= '0;
      release_l <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      id <= rec_in.id;
    end
  end

  assign rec = '{id: id, count: count, press: press, release_l: release_l};

endmodule
`default_nettype wire

// ===== rtl/input_action_edge_tracker.sv =====
// top level of the input action edge tracker
// Bindings and actions live in two rings of cells that rotate one place per cycle during a
// pass, past a single head position, where all compares and updates happen but for
// reset-all, which clears every cell in place. A load runs a scan pass, a write pass and an
// action pass, or only the scan pass when it is refused as a duplicate. A bound event runs
// a scan pass and an action pass, an unbound one only the scan pass. Reset-all, events
// refused for device or budget, and loads refused for device go straight to the response.
// An end frame runs one pass over the action ring, held by any output stall while rows are
// taken. One item is worked at a time; the input stalls until that item is done.
`default_nettype none
module input_action_edge_tracker import iaet_pkg::*; #(
  parameter int BINDINGS    = BINDINGS_DEF,
  parameter int ACTIONS     = ACTIONS_DEF,
  parameter int EVENT_LIMIT = EVENT_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [4:0]  slot,
  input  wire logic [2:0]  device,
  input  wire logic [15:0] code,
  input  wire logic        pressed,
  input  wire logic [3:0]  action_slot,
  input  wire logic [31:0] action_id,
  input  wire logic        entry_valid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [31:0]      row_action_id,
  output logic             held,
  output logic             press_seen,
  output logic             release_seen,
  output logic [63:0]      frame_seq,
  output logic [9:0]       accepted_count,
  output logic [15:0]      rejected_count,
  output logic [31:0]      total_rejected,
  output logic             last
);

  localparam int MAXN = (BINDINGS > ACTIONS) ? BINDINGS : ACTIONS;
  localparam int SW   = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int CW   = (SW > 7) ? SW : 7;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WRITE = 6'b000100,
    S_ACT   = 6'b001000,
    S_DUMP  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  function automatic logic [CW-1:0] slot_mod(input logic [4:0] v);
    logic [CW-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v == 5'(i)) r = CW'(i % BINDINGS);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] act_mod(input logic [3:0] v);
    logic [CW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) r = CW'(i % ACTIONS);
    end
    return r;
  endfunction

  state_t state, state_next;

  logic [9:0]  event_budget;
  logic [4:0]  actions_in_use;
  logic [63:0] frame_number;
  logic [9:0]  frame_accepted;
  logic [15:0] frame_rejected;
  logic [31:0] total_rejected_count;

  mode_t         lat_mode;
  logic [CW-1:0] lat_slot;
  logic [2:0]    lat_device;
  logic [15:0]   lat_code;
  logic          lat_pressed;
  logic [CW-1:0] lat_act;
  logic [31:0]   lat_id;
  logic          lat_entry;

  logic          found, dup, op_inc, op_dec;
  logic [TGT_W-1:0] op_tgt;
  logic [2:0]    resp_status;
  logic [SW-1:0] k;
  logic [CW-1:0] kc;

  bind_rec_t bq [BINDINGS];
  act_rec_t  aq [ACTIONS];
  bind_rec_t bhead;
  act_rec_t  ahead;
  bind_ctl_t bctl;
  act_ctl_t  actl;

  logic accept, out_free, known, over_budget, head_match;
  logic [CW-1:0] n_rows;
  logic bind_last, act_last, adv, pass_end, row_wr, resp_wr;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign kc       = CW'(k);
  assign known    = device < DEV_FIRST_UNKNOWN;
  assign over_budget = ({7'b0, frame_accepted} >= {7'b0, event_budget})
                    || ({7'b0, frame_accepted} >= 17'(EVENT_LIMIT));

  always_comb begin
    if (actions_in_use == 5'd0) begin
      n_rows = CW'(1);
    end else if (CW'(actions_in_use) > CW'(ACTIONS)) begin
      n_rows = CW'(ACTIONS);
    end else begin
      n_rows = CW'(actions_in_use);
    end
  end

  assign bind_last = (kc == CW'(BINDINGS - 1));
  assign act_last  = (kc == CW'(ACTIONS - 1));
  assign row_wr    = (state == S_DUMP) && (kc < n_rows) && out_free;
  assign adv       = (state == S_DUMP) && ((kc >= n_rows) || out_free);
  assign resp_wr   = (state == S_RESP) && out_free;
  assign pass_end  = (((state == S_SCAN) || (state == S_WRITE)) && bind_last)
                  || ((state == S_ACT) && act_last) || (adv && act_last);

  assign head_match = bq[0].valid && bq[0].device == lat_device && bq[0].code == lat_code;

  // ring control
  assign bctl.shift      = (state == S_SCAN) || (state == S_WRITE);
  assign bctl.clear_down = accept && mode_t'(mode) == MODE_RESET;
  assign actl.shift      = (state == S_ACT) || adv;
  assign actl.release_all = bctl.clear_down;

  // binding head update
  always_comb begin
    bhead = bq[0];
    if (state == S_SCAN && lat_mode == MODE_EVENT && head_match && !found) begin
      bhead.down = lat_pressed;
    end
    if (state == S_WRITE && kc == lat_slot) begin
      bhead.down = 1'b0;
      if (lat_entry) begin
        bhead.valid  = 1'b1;
        bhead.device = lat_device;
        bhead.code   = lat_code;
        bhead.target = TGT_W'(lat_act);
      end else begin
        bhead.valid = 1'b0;
      end
    end
  end

  // action head update
  always_comb begin
    ahead = aq[0];
    if (state == S_ACT) begin
      if (kc == CW'(op_tgt)) begin
        if (op_inc) begin
          if (aq[0].count == '0) ahead.press = 1'b1;
          if (aq[0].count != COUNT_MAX) ahead.count = aq[0].count + 1'b1;
        end
        if (op_dec && aq[0].count != '0) begin
          ahead.count = aq[0].count - 1'b1;
          if (aq[0].count == COUNT_W'(1)) ahead.release_l = 1'b1;
        end
      end
      if (kc == lat_act && lat_mode == MODE_LOAD && lat_entry) begin
        ahead.id = lat_id;
      end
    end
    if (state == S_DUMP) begin
      ahead.press     = 1'b0;
      ahead.release_l = 1'b0;
    end
  end

  for (genvar i = 0; i < BINDINGS; i++) begin : g_bind
    iaet_bind_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (bctl),
      .rec_in ((i == BINDINGS - 1) ? bhead : bq[(i + 1) % BINDINGS]),
      .rec    (bq[i])
    );
  end

  for (genvar i = 0; i < ACTIONS; i++) begin : g_act
    iaet_act_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (actl),
      .rec_in ((i == ACTIONS - 1) ? ahead : aq[(i + 1) % ACTIONS]),
      .rec    (aq[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_LOAD:  state_next = (entry_valid && !known) ? S_RESP : S_SCAN;
            MODE_EVENT: state_next = (!known || over_budget) ? S_RESP : S_SCAN;
            MODE_RESET: state_next = S_RESP;
            MODE_END:   state_next = S_DUMP;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (bind_last) begin
          if (lat_mode == MODE_LOAD) begin
            state_next = (lat_entry && (dup || (kc != lat_slot && head_match)))
                       ? S_RESP : S_WRITE;
          end else begin
            state_next = (found || (head_match && !found)) ? S_ACT : S_RESP;
          end
        end
      end
      S_WRITE: if (bind_last) state_next = S_ACT;
      S_ACT:   if (act_last) state_next = S_RESP;
      S_DUMP:  if (adv && act_last) state_next = S_IDLE;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (pass_end) begin
        k <= '0;
      end else if (bctl.shift || actl.shift) begin
        k <= k + 1'b1;
      end
    end
  end

  // configuration and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      event_budget         <= 10'd64;
      actions_in_use       <= 5'd1;
      frame_number         <= '0;
      frame_accepted       <= '0;
      frame_rejected       <= '0;
      total_rejected_count <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_EVENT_BUDGET:   event_budget <= cfg_data;
          REG_ACTIONS_IN_USE: actions_in_use <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (accept && mode_t'(mode) == MODE_EVENT) begin
        if (!known || over_budget) begin
          if (frame_rejected != '1) frame_rejected <= frame_rejected + 1'b1;
          if (total_rejected_count != '1) total_rejected_count <= total_rejected_count + 1'b1;
        end else begin
          frame_accepted <= frame_accepted + 1'b1;
        end
      end
      if (adv && act_last) begin
        frame_number   <= frame_number + 1'b1;
        frame_accepted <= '0;
        frame_rejected <= '0;
      end
    end
  end

  // item latch and search results
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_mode    <= mode_t'(mode);
      lat_slot    <= slot_mod(slot);
      lat_device  <= device;
      lat_code    <= code;
      lat_pressed <= pressed;
      lat_act     <= act_mod(action_slot);
      lat_id      <= action_id;
      lat_entry   <= entry_valid;
      found       <= 1'b0;
      dup         <= 1'b0;
      op_inc      <= 1'b0;
      op_dec      <= 1'b0;
      resp_status <= ST_OK;
      unique case (mode_t'(mode))
        MODE_LOAD:  if (entry_valid && !known) resp_status <= ST_LOAD_DEV;
        MODE_EVENT: begin
          if (!known) resp_status <= ST_BAD_DEV;
          else if (over_budget) resp_status <= ST_BUDGET;
        end
        default: ;
      endcase
    end else if (state == S_SCAN) begin
      if (lat_mode == MODE_LOAD) begin
        if (kc == lat_slot) begin
          op_dec <= bq[0].down;
          op_tgt <= bq[0].target;
        end else if (head_match) begin
          dup <= 1'b1;
        end
        if (bind_last && lat_entry && (dup || (kc != lat_slot && head_match))) begin
          resp_status <= ST_DUPLICATE;
        end
      end else begin
        if (head_match && !found) begin
          found  <= 1'b1;
          op_tgt <= bq[0].target;
          op_inc <= lat_pressed && !bq[0].down;
          op_dec <= !lat_pressed && bq[0].down;
        end
        if (bind_last && !found && !head_match) resp_status <= ST_UNBOUND;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (row_wr || resp_wr) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_wr) begin
      status         <= resp_status;
      row_action_id  <= '0;
      held           <= 1'b0;
      press_seen     <= 1'b0;
      release_seen   <= 1'b0;
      frame_seq      <= '0;
      accepted_count <= '0;
      rejected_count <= '0;
      total_rejected <= '0;
      last           <= 1'b1;
    end else if (row_wr) begin
      status         <= ST_OK;
      row_action_id  <= aq[0].id;
      held           <= (aq[0].count != '0);
      press_seen     <= aq[0].press;
      release_seen   <= aq[0].release_l;
      frame_seq      <= frame_number;
      accepted_count <= frame_accepted;
      rejected_count <= frame_rejected;
      total_rejected <= total_rejected_count;
      last           <= (kc == n_rows - 1'b1);
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("item transfer left the block idle");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_WRITE) |-> kc <= CW'(BINDINGS - 1))
    else $error("binding pass ran past the ring");

  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (adv && act_last) |=> frame_accepted == '0 && state == S_IDLE)
    else $error("frame counters not cleared at frame end");

endmodule
`default_nettype wire

// ===== dv/input_action_edge_tracker_tb.sv =====
// self-checking testbench of the input action edge tracker: binding loads, events, frame rows
`default_nettype none
module input_action_edge_tracker_tb import iaet_pkg::*; ();

  typedef struct {
    mode_t       mode;
    logic [4:0]  slot;
    logic [2:0]  device;
    logic [15:0] code;
    logic        pressed;
    logic [3:0]  action_slot;
    logic [31:0] action_id;
    logic        entry_valid;
  } item_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] row_action_id;
    logic        held;
    logic        press_seen;
    logic        release_seen;
    logic [63:0] frame_seq;
    logic [9:0]  accepted_count;
    logic [15:0] rejected_count;
    logic [31:0] total_rejected;
    logic        last;
  } row_t;

  class tracker_scoreboard;
    bit [9:0]  budget = 10'd64;
    bit [4:0]  in_use = 5'd1;
    bit        bvalid[32];
    bit [2:0]  bdev[32];
    bit [15:0] bcode[32];
    bit [3:0]  btgt[32];
    bit        bdown[32];
    bit [31:0] ids[16];
    bit [5:0]  dcount[16];
    bit        plat[16];
    bit        rlat[16];
    bit [63:0] frame_no;
    bit [9:0]  f_acc;
    bit [15:0] f_rej;
    bit [31:0] t_rej;
    row_t      pending[$];
    int        mismatches;

    function void release_control(int b);
      if (!bdown[b]) return;
      bdown[b] = 0;
      if (dcount[btgt[b]] > 0) begin
        dcount[btgt[b]]--;
        if (dcount[btgt[b]] == 0) rlat[btgt[b]] = 1;
      end
    endfunction

    function void count_reject();
      if (f_rej != 16'hFFFF) f_rej++;
      if (t_rej != 32'hFFFFFFFF) t_rej++;
    endfunction

    function logic [2:0] load(item_t it);
      int s;
      s = int'(it.slot);
      if (!it.entry_valid) begin
        release_control(s);
        bvalid[s] = 0;
        return ST_OK;
      end
      if (it.device >= DEV_FIRST_UNKNOWN) return ST_LOAD_DEV;
      for (int i = 0; i < 32; i++)
        if (i != s && bvalid[i] && bdev[i] == it.device && bcode[i] == it.code)
          return ST_DUPLICATE;
      release_control(s);
      bvalid[s] = 1;
      bdev[s] = it.device;
      bcode[s] = it.code;
      btgt[s] = it.action_slot;
      ids[it.action_slot] = it.action_id;
      return ST_OK;
    endfunction

    function logic [2:0] event_in(item_t it);
      int hit;
      bit [3:0] a;
      hit = -1;
      if (it.device >= DEV_FIRST_UNKNOWN) begin
        count_reject();
        return ST_BAD_DEV;
      end
      if (f_acc >= budget) begin
        count_reject();
        return ST_BUDGET;
      end
      f_acc++;
      for (int i = 31; i >= 0; i--)
        if (bvalid[i] && bdev[i] == it.device && bcode[i] == it.code) hit = i;
      if (hit < 0) return ST_UNBOUND;
      a = btgt[hit];
      if (it.pressed && !bdown[hit]) begin
        bdown[hit] = 1;
        if (dcount[a] == 0) plat[a] = 1;
        if (dcount[a] < 63) dcount[a]++;
      end else if (!it.pressed && bdown[hit]) begin
        release_control(hit);
      end
      return ST_OK;
    endfunction

    function void note(item_t it);
      row_t r;
      int n;
      r = '{default: 0};
      r.last = 1;
      case (it.mode)
        MODE_LOAD:  r.status = load(it);
        MODE_EVENT: r.status = event_in(it);
        MODE_RESET: begin
          foreach (bdown[i]) bdown[i] = 0;
          foreach (dcount[i])
            if (dcount[i] != 0) begin
              dcount[i] = 0;
              rlat[i] = 1;
            end
        end
        default: begin
          n = (in_use == 0) ? 1 : (in_use > 16) ? 16 : int'(in_use);
          for (int i = 0; i < n; i++) begin
            r.row_action_id = ids[i];
            r.held = dcount[i] > 0;
            r.press_seen = plat[i];
            r.release_seen = rlat[i];
            r.frame_seq = frame_no;
            r.accepted_count = f_acc;
            r.rejected_count = f_rej;
            r.total_rejected = t_rej;
            r.last = (i == n - 1);
            pending = {pending, r};
          end
          foreach (plat[i]) begin
            plat[i] = 0;
            rlat[i] = 0;
          end
          frame_no++;
          f_acc = 0;
          f_rej = 0;
          return;
        end
      endcase
      pending = {pending, r};
    endfunction

    function void check(row_t got);
      row_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.row_action_id !== e.row_action_id ||
          got.held !== e.held || got.press_seen !== e.press_seen ||
          got.release_seen !== e.release_seen || got.frame_seq !== e.frame_seq ||
          got.accepted_count !== e.accepted_count ||
          got.rejected_count !== e.rejected_count ||
          got.total_rejected !== e.total_rejected || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", e, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  logic [0:0]  cfg_index = REG_EVENT_BUDGET;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  mode = MODE_RESET;
  logic [4:0]  slot = '0;
  logic [2:0]  device = '0;
  logic [15:0] code = '0;
  logic        pressed = 0;
  logic [3:0]  action_slot = '0;
  logic [31:0] action_id = '0;
  logic        entry_valid = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic [31:0] row_action_id;
  logic        held, press_seen, release_seen, last;
  logic [63:0] frame_seq;
  logic [9:0]  accepted_count;
  logic [15:0] rejected_count;
  logic [31:0] total_rejected;

  tracker_scoreboard sb = new();
  bit quiet = 0;
  int idle_cycles = 0;
  bit [15:0] code_pool[8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                              16'h1234, 16'h00FF, 16'h0002, 16'hA5A5};

  input_action_edge_tracker dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check('{status, row_action_id, held, press_seen, release_seen, frame_seq,
                   accepted_count, rejected_count, total_rejected, last});
      out_stall <= !quiet && ($urandom_range(99) < 11);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(item_t it);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    mode <= it.mode;
    slot <= it.slot;
    device <= it.device;
    code <= it.code;
    pressed <= it.pressed;
    action_slot <= it.action_slot;
    action_id <= it.action_id;
    entry_valid <= it.entry_valid;
    do @(posedge clk); while (in_stall);
    sb.note(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [9:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
    if (idx == REG_EVENT_BUDGET) sb.budget = val;
    else sb.in_use = val[4:0];
  endtask

  function automatic item_t make(mode_t m, int s, int d, int c, bit p, int a, bit [31:0] id,
                                 bit v);
    item_t it;
    it = '{m, s[4:0], d[2:0], c[15:0], p, a[3:0], id, v};
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(99);
    it.mode = pick < 30 ? MODE_LOAD : pick < 80 ? MODE_EVENT : pick < 85 ? MODE_RESET : MODE_END;
    it.slot = 5'($urandom_range(31));
    it.device = 3'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(2));
    it.code = ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                       : code_pool[$urandom_range(7)];
    it.pressed = 1'($urandom_range(1));
    it.action_slot = 4'($urandom_range(15));
    it.action_id = $urandom;
    it.entry_valid = $urandom_range(9) != 0;
    return it;
  endfunction

  initial begin
    int cfg_budget[4] = '{1023, 0, 5, 64};
    int cfg_use[4] = '{16, 0, 31, 7};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // every action id written first, extremes of slot, code and id
    for (int i = 0; i < 16; i++)
      send(make(MODE_LOAD, i == 15 ? 31 : i, i % 3, i == 0 ? 0 : i == 1 ? 65535 : i * 7,
                0, i, i == 0 ? 32'h0 : i == 1 ? 32'hFFFFFFFF : $urandom, 1));
    send(make(MODE_LOAD, 20, 7, 5, 0, 3, 32'h1, 1));          // bad load device
    send(make(MODE_LOAD, 21, 1, 65535, 0, 3, 32'h2, 1));      // duplicate binding
    send(make(MODE_EVENT, 0, 0, 0, 1, 0, 0, 0));              // press
    send(make(MODE_EVENT, 0, 1, 65535, 1, 0, 0, 0));
    send(make(MODE_EVENT, 0, 5, 0, 1, 0, 0, 0));              // unknown device
    send(make(MODE_EVENT, 0, 2, 4321, 1, 0, 0, 0));           // unbound
    send(make(MODE_LOAD, 1, 7, 0, 0, 0, 0, 0));               // clearing load over held control
    send(make(MODE_RESET, 0, 0, 0, 0, 0, 0, 0));
    send(make(MODE_END, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_EVENT_BUDGET, 10'(cfg_budget[ph]));
      write_reg(REG_ACTIONS_IN_USE, 10'(cfg_use[ph]));
      quiet = (ph == 2);
      for (int n = 0; n < (ph == 1 ? 50 : 105); n++) send(random_item());
      send(make(MODE_END, 0, 0, 0, 0, 0, 0, 0));
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
